// File: hw/rtl/ocs_pkg.sv
package ocs_pkg;

    localparam int VW            = 48;
    localparam int GW            = 20;
    localparam int MPW           = 48;
    localparam int QW            = 48;
    localparam int DGW           = VW + GW;
    localparam int ALU_W         = DGW + QW;
    localparam int IDXW          = 2;
    localparam int FRAC_BITS_DEF = 32;

    localparam logic [IDXW-1:0] CFG_GAIN   = 2'd0;
    localparam logic [IDXW-1:0] CFG_SUP_HI = 2'd1;
    localparam logic [IDXW-1:0] CFG_SUP_LO = 2'd2;

    localparam logic [GW-1:0]        GAIN_RST   = 20'd1000;
    localparam logic signed [VW-1:0] SUP_HI_RST = 48'sd21474836480;
    localparam logic signed [VW-1:0] SUP_LO_RST = 48'sd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_MUL_VG,
        S_TGT,
        S_CHECK,
        S_DIN,
        S_MUL_DG,
        S_MUL_T1,
        S_MUL_T2,
        S_NUM,
        S_NEG,
        S_DEN,
        S_OVF,
        S_DIV,
        S_QSAT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [GW-1:0]        gain;
        logic signed [VW-1:0] sup_hi;
        logic signed [VW-1:0] sup_lo;
    } t_cfg;

    typedef struct packed {
        logic signed [VW-1:0] volt;
        logic                 conv;
    } t_result;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_in;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             carry;
    } t_alu_out;

endpackage

// File: hw/rtl/ocs_alu.sv
module ocs_alu (
    input  ocs_pkg::t_alu_in  i_op,
    output ocs_pkg::t_alu_out o_res
);

    localparam int ALU_W = ocs_pkg::ALU_W;

    logic [ALU_W:0] w_sum;

    // carry high on subtract means a >= b
    assign w_sum = {1'b0, i_op.a} + {1'b0, (i_op.sub ? ~i_op.b : i_op.b)}
                 + {{ALU_W{1'b0}}, i_op.sub};

    assign o_res.sum   = w_sum[ALU_W-1:0];
    assign o_res.carry = w_sum[ALU_W];

endmodule

// File: hw/rtl/ocs_core.sv
module ocs_core #(
    parameter int FRAC_BITS = ocs_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [47:0]    i_v_plus,
    input  logic signed [47:0]    i_v_minus,
    input  ocs_pkg::t_cfg         i_cfg,
    input  logic                  i_out_free,
    output logic                  o_idle,
    output logic                  o_res_valid,
    output ocs_pkg::t_result      o_res
);

    localparam int VW    = ocs_pkg::VW;
    localparam int GW    = ocs_pkg::GW;
    localparam int MPW   = ocs_pkg::MPW;
    localparam int QW    = ocs_pkg::QW;
    localparam int DGW   = ocs_pkg::DGW;
    localparam int ALU_W = ocs_pkg::ALU_W;
    localparam int CW    = $clog2(QW);

    localparam logic [63:0] EPS5_W = ((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000;
    localparam logic [63:0] EPS6_W = ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam logic [VW:0]    EPS5 = EPS5_W[VW:0];
    localparam logic [MPW-1:0] EPS6 = EPS6_W[MPW-1:0];
    localparam logic signed [VW:0] EPS6_S = $signed(EPS6_W[VW:0]);

    localparam logic signed [VW-1:0] S_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] S_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [DGW-1:0] MAG_MAX = {{(DGW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic [DGW-1:0] MAG_MIN = MAG_MAX + {{(DGW-1){1'b0}}, 1'b1};

    function automatic logic signed [VW-1:0] sat(input logic signed [VW:0] v);
        if (v[VW] != v[VW-1]) begin
            sat = v[VW] ? S_MIN : S_MAX;
        end else begin
            sat = v[VW-1:0];
        end
    endfunction

    function automatic logic signed [VW-1:0] clamp(input logic signed [VW-1:0] v,
                                                   input logic signed [VW-1:0] hi,
                                                   input logic signed [VW-1:0] lo);
        priority if (v >= hi) begin
            clamp = hi;
        end else if (v <= lo) begin
            clamp = lo;
        end else begin
            clamp = v;
        end
    endfunction

    ocs_pkg::t_state   r_state, n_state;
    ocs_pkg::t_alu_in  w_alu_in;
    ocs_pkg::t_alu_out w_alu_out;

    logic signed [VW-1:0] r_vd, r_tgt, r_res, r_prev_out, r_prev_diff;
    logic                 r_settled, r_next_settled;
    logic [GW-1:0]        r_g;
    logic [DGW-1:0]       r_vg, r_den, r_rem;
    logic [ALU_W-1:0]     r_acc, r_mcand, r_t1;
    logic [MPW-1:0]       r_mplier;
    logic [QW-1:0]        r_q;
    logic [CW-1:0]        r_cnt;
    logic                 r_np, r_nv, r_neg;

    logic signed [VW-1:0] w_vd_in, w_tgt_sat, w_nudge, w_qsat, w_res_clamped;
    logic [GW-1:0]        w_gain_eff;
    logic [MPW-1:0]       w_mvd, w_mp, w_d;
    logic signed [VW:0]   w_cdiff, w_cabs, w_ddiff, w_dabs;
    logic                 w_converged, w_mul_done, w_signs_differ, w_np0, w_np, w_nv;
    logic [DGW:0]         w_rem_sh;

    ocs_alu u_alu (
        .i_op  (w_alu_in),
        .o_res (w_alu_out)
    );

    assign w_vd_in    = sat({i_v_plus[VW-1], i_v_plus} - {i_v_minus[VW-1], i_v_minus});
    assign w_gain_eff = (i_cfg.gain == '0) ? {{(GW-1){1'b0}}, 1'b1} : i_cfg.gain;
    assign w_mvd      = r_vd[VW-1] ? MPW'(-r_vd) : MPW'(r_vd);
    assign w_mp       = r_prev_out[VW-1] ? MPW'(-r_prev_out) : MPW'(r_prev_out);
    assign w_mul_done = (r_mplier == '0);

    always_comb begin
        if (r_vd[VW-1]) begin
            w_tgt_sat = (r_vg > MAG_MIN) ? S_MIN : -$signed(r_vg[VW-1:0]);
        end else begin
            w_tgt_sat = (r_vg > MAG_MAX) ? S_MAX : $signed(r_vg[VW-1:0]);
        end
    end

    assign w_cdiff     = {r_tgt[VW-1], r_tgt} - {r_prev_out[VW-1], r_prev_out};
    assign w_cabs      = w_cdiff[VW] ? -w_cdiff : w_cdiff;
    assign w_converged = (w_cabs < $signed(EPS5));
    assign w_nudge     = sat({r_prev_out[VW-1], r_prev_out}
                             + ((r_vd > 0) ? EPS6_S : -EPS6_S));

    assign w_ddiff = {r_prev_diff[VW-1], r_prev_diff} - {r_vd[VW-1], r_vd};
    assign w_dabs  = w_ddiff[VW] ? -w_ddiff : w_ddiff;
    assign w_d     = (w_dabs > {1'b0, S_MAX}) ? MPW'(S_MAX) : MPW'(w_dabs);

    // zero magnitude takes the sign of the other term
    assign w_np0 = r_prev_out[VW-1];
    assign w_np  = (r_prev_out == '0) ? r_vd[VW-1] : w_np0;
    assign w_nv  = (r_vd == '0) ? w_np : r_vd[VW-1];
    assign w_signs_differ = (r_np != r_nv);

    assign w_rem_sh = {r_rem, r_t1[QW-1]};

    always_comb begin
        if (r_neg) begin
            w_qsat = r_q[QW-1] ? S_MIN : -$signed(r_q);
        end else begin
            w_qsat = r_q[QW-1] ? S_MAX : $signed(r_q);
        end
    end

    assign w_res_clamped = clamp(r_res, i_cfg.sup_hi, i_cfg.sup_lo);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ocs_pkg::S_IDLE:   if (i_start) n_state = ocs_pkg::S_DIFF;
            ocs_pkg::S_DIFF:   n_state = ocs_pkg::S_MUL_VG;
            ocs_pkg::S_MUL_VG: if (w_mul_done) n_state = ocs_pkg::S_TGT;
            ocs_pkg::S_TGT:    n_state = ocs_pkg::S_CHECK;
            ocs_pkg::S_CHECK: begin
                priority if (w_converged) begin
                    n_state = ocs_pkg::S_IDLE;
                end else if (r_settled || r_prev_diff == r_vd) begin
                    n_state = ocs_pkg::S_FINISH;
                end else begin
                    n_state = ocs_pkg::S_DIN;
                end
            end
            ocs_pkg::S_DIN:    n_state = ocs_pkg::S_MUL_DG;
            ocs_pkg::S_MUL_DG: if (w_mul_done) n_state = ocs_pkg::S_MUL_T1;
            ocs_pkg::S_MUL_T1: if (w_mul_done) n_state = ocs_pkg::S_MUL_T2;
            ocs_pkg::S_MUL_T2: if (w_mul_done) n_state = ocs_pkg::S_NUM;
            ocs_pkg::S_NUM: begin
                n_state = (!w_signs_differ || w_alu_out.carry) ? ocs_pkg::S_DEN
                                                               : ocs_pkg::S_NEG;
            end
            ocs_pkg::S_NEG:    n_state = ocs_pkg::S_DEN;
            ocs_pkg::S_DEN:    n_state = ocs_pkg::S_OVF;
            ocs_pkg::S_OVF: begin
                n_state = w_alu_out.carry ? ocs_pkg::S_FINISH : ocs_pkg::S_DIV;
            end
            ocs_pkg::S_DIV:    if (r_cnt == CW'(QW - 1)) n_state = ocs_pkg::S_QSAT;
            ocs_pkg::S_QSAT:   n_state = ocs_pkg::S_FINISH;
            ocs_pkg::S_FINISH: if (i_out_free) n_state = ocs_pkg::S_IDLE;
            default:           n_state = ocs_pkg::S_IDLE;
        endcase
    end

    // shared adder operands, handshake outputs and result outputs
    always_comb begin
        w_alu_in = '0;
        unique case (r_state)
            ocs_pkg::S_MUL_VG, ocs_pkg::S_MUL_DG, ocs_pkg::S_MUL_T1, ocs_pkg::S_MUL_T2: begin
                w_alu_in.a = r_acc;
                w_alu_in.b = r_mplier[0] ? r_mcand : '0;
            end
            ocs_pkg::S_NUM: begin
                w_alu_in.a   = r_t1;
                w_alu_in.b   = r_acc;
                w_alu_in.sub = w_signs_differ;
            end
            ocs_pkg::S_NEG: begin
                w_alu_in.b   = r_t1;
                w_alu_in.sub = 1'b1;
            end
            ocs_pkg::S_DEN: begin
                w_alu_in.a = ALU_W'(r_den);
                w_alu_in.b = ALU_W'(EPS6);
            end
            ocs_pkg::S_OVF: begin
                w_alu_in.a   = ALU_W'(r_t1[ALU_W-1:QW]);
                w_alu_in.b   = ALU_W'(r_den);
                w_alu_in.sub = 1'b1;
            end
            ocs_pkg::S_DIV: begin
                w_alu_in.a   = ALU_W'(w_rem_sh);
                w_alu_in.b   = ALU_W'(r_den);
                w_alu_in.sub = 1'b1;
            end
            default: w_alu_in = '0;
        endcase
        o_idle      = (r_state == ocs_pkg::S_IDLE);
        o_res_valid = (r_state == ocs_pkg::S_FINISH) && i_out_free;
        o_res.volt  = w_res_clamped;
        o_res.conv  = r_next_settled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ocs_pkg::S_IDLE;
            r_prev_out  <= '0;
            r_prev_diff <= '0;
            r_settled   <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == ocs_pkg::S_CHECK && w_converged) begin
                r_settled <= 1'b1;
            end
            if (o_res_valid) begin
                r_prev_out  <= w_res_clamped;
                r_prev_diff <= r_vd;
                r_settled   <= r_next_settled;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ocs_pkg::S_IDLE: begin
                if (i_start) begin
                    r_vd <= w_vd_in;
                    r_g  <= w_gain_eff;
                end
            end
            ocs_pkg::S_DIFF: begin
                r_mcand  <= ALU_W'(w_mvd);
                r_mplier <= MPW'(r_g);
                r_acc    <= '0;
            end
            ocs_pkg::S_MUL_VG, ocs_pkg::S_MUL_DG, ocs_pkg::S_MUL_T1, ocs_pkg::S_MUL_T2: begin
                if (!w_mul_done) begin
                    r_acc    <= w_alu_out.sum;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                end else if (r_state == ocs_pkg::S_MUL_VG) begin
                    r_vg <= r_acc[DGW-1:0];
                end else if (r_state == ocs_pkg::S_MUL_DG) begin
                    r_den    <= r_acc[DGW-1:0];
                    r_mcand  <= r_acc;
                    r_mplier <= w_mp;
                    r_acc    <= '0;
                end else if (r_state == ocs_pkg::S_MUL_T1) begin
                    r_t1     <= r_acc;
                    r_mcand  <= ALU_W'(r_vg);
                    r_mplier <= EPS6;
                    r_acc    <= '0;
                end
            end
            ocs_pkg::S_TGT: begin
                r_tgt <= clamp(w_tgt_sat, i_cfg.sup_hi, i_cfg.sup_lo);
            end
            ocs_pkg::S_CHECK: begin
                r_res          <= r_settled ? w_nudge : r_tgt;
                r_next_settled <= !r_settled;
            end
            ocs_pkg::S_DIN: begin
                r_mcand  <= ALU_W'(w_d);
                r_mplier <= MPW'(r_g);
                r_acc    <= '0;
                r_np     <= w_np;
                r_nv     <= w_nv;
            end
            ocs_pkg::S_NUM: begin
                r_t1  <= w_alu_out.sum;
                r_neg <= (w_signs_differ && !w_alu_out.carry) ? r_nv : r_np;
            end
            ocs_pkg::S_NEG: begin
                r_t1 <= w_alu_out.sum;
            end
            ocs_pkg::S_DEN: begin
                r_den <= w_alu_out.sum[DGW-1:0];
            end
            ocs_pkg::S_OVF: begin
                if (w_alu_out.carry) begin
                    r_res <= r_neg ? S_MIN : S_MAX;
                end else begin
                    r_rem <= r_t1[ALU_W-1:QW];
                    r_cnt <= '0;
                end
            end
            ocs_pkg::S_DIV: begin
                r_rem <= w_alu_out.carry ? w_alu_out.sum[DGW-1:0] : w_rem_sh[DGW-1:0];
                r_q   <= {r_q[QW-2:0], w_alu_out.carry};
                r_t1  <= r_t1 << 1;
                r_cnt <= r_cnt + CW'(1);
            end
            ocs_pkg::S_QSAT: begin
                r_res <= w_qsat;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hw/rtl/opamp_convergence_step.sv
// Op-amp solver step. The slave stream takes one beat per step with both pin
// voltages; the master stream returns the new output voltage and the
// converged flag. A step whose clamped target is already within the
// convergence band of the last output returns no beat at all.
// The config channel writes gain, upper rail and lower rail by index; write
// it only while the block is idle. o_cfg_ready is always high.
// One step at a time: s_tready drops for the whole step. The datapath uses
// one shared 116-bit adder: multiplies run one multiplier bit per cycle,
// ending early once the remaining bits are zero, and the quotient is a
// 48-step restoring division on the same adder. A converged step or a nudge
// or direct step needs only the gain multiply; a blended step adds three
// more multiplies and, unless the quotient overflows, the divide. Gain and
// operand widths set the multiply lengths.
// The result sits in an output register, so the next step is accepted while
// a beat waits; if the receiver still stalls when the next result is ready,
// the core holds in its final state until the register is free.
// Reset clears the state to last output 0, last difference 0, converged set,
// and loads gain 1000, upper rail 5.0 V and lower rail 0 V.
module opamp_convergence_step #(
    parameter int FRAC_BITS = ocs_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,    // v_plus[47:0], v_minus[95:48]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,    // out_volt[47:0]
    output logic        o_m_tuser,    // now_converged[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    localparam int VW = ocs_pkg::VW;
    localparam int GW = ocs_pkg::GW;

    ocs_pkg::t_cfg    r_cfg;
    ocs_pkg::t_result w_res;
    ocs_pkg::t_result r_m_res;
    logic             r_m_valid;
    logic             w_idle, w_res_valid, w_out_free, w_start;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = w_idle;
    assign w_start     = i_s_tvalid && w_idle;
    assign w_out_free  = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain   <= ocs_pkg::GAIN_RST;
            r_cfg.sup_hi <= ocs_pkg::SUP_HI_RST;
            r_cfg.sup_lo <= ocs_pkg::SUP_LO_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ocs_pkg::CFG_GAIN:   r_cfg.gain   <= i_cfg_data[GW-1:0];
                ocs_pkg::CFG_SUP_HI: r_cfg.sup_hi <= $signed(i_cfg_data[VW-1:0]);
                ocs_pkg::CFG_SUP_LO: r_cfg.sup_lo <= $signed(i_cfg_data[VW-1:0]);
                default: begin
                end
            endcase
        end
    end

    ocs_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_v_plus    ($signed(i_s_tdata[VW-1:0])),
        .i_v_minus   ($signed(i_s_tdata[2*VW-1:VW])),
        .i_cfg       (r_cfg),
        .i_out_free  (w_out_free),
        .o_idle      (w_idle),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_m_res <= w_res;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_res.volt;
    assign o_m_tuser  = r_m_res.conv;

endmodule

// File: hw/rtl/ocs_checker.sv
module ocs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic        o_m_tuser
);

    // one step at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while a step is in progress");

    // no result can appear straight out of an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !$rose(o_m_tvalid))
        else $error("result appeared one cycle after accept");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled output beat changed");

endmodule

bind opamp_convergence_step ocs_checker u_ocs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// File: bench/opamp_convergence_step_checker.sv
`timescale 1ns / 1ps
module opamp_convergence_step_checker #(
    parameter int FRAC_BITS = ocs_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [95:0] i_s_tdata,    // v_plus[47:0], v_minus[95:48]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,    // out_volt[47:0]
    input  logic        i_m_tuser,    // now_converged[0]
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_beats,
    output int          o_quiet
);

    typedef logic signed [139:0] t_wide;

    localparam longint V_MAX = (longint'(1) <<< 47) - 1;
    localparam longint V_MIN = -(longint'(1) <<< 47);
    localparam longint BAND  = ((longint'(1) <<< FRAC_BITS) + 50000) / 100000;
    localparam longint NUDGE = ((longint'(1) <<< FRAC_BITS) + 500000) / 1000000;

    longint           gain_now;
    longint           rail_hi;
    longint           rail_lo;
    longint           last_out;
    longint           last_diff;
    logic             at_rest;
    ocs_pkg::t_result out_due[$];
    int               errs = 0;
    int               beats = 0;
    int               quiet = 0;

    function automatic longint clip48(input t_wide v);
        if (v > t_wide'(V_MAX)) return V_MAX;
        if (v < t_wide'(V_MIN)) return V_MIN;
        return longint'(v);
    endfunction

    function automatic longint to_rails(input longint v);
        if (v >= rail_hi) return rail_hi;
        if (v <= rail_lo) return rail_lo;
        return v;
    endfunction

    // exact signed quotient, truncated toward zero
    function automatic longint blended(input longint p, input longint v,
                                       input longint d, input longint g);
        t_wide num;
        t_wide den;
        num = t_wide'(g) * (t_wide'(p) * t_wide'(d) + t_wide'(v) * t_wide'(NUDGE));
        den = t_wide'(g) * t_wide'(d) + t_wide'(NUDGE);
        return clip48(num / den);
    endfunction

    function automatic bit next_output(input longint vp, input longint vm,
                                       output ocs_pkg::t_result r);
        longint g;
        longint vd;
        longint tgt;
        longint delta;
        longint res;
        g     = (gain_now == 0) ? 1 : gain_now;
        vd    = clip48(t_wide'(vp) - t_wide'(vm));
        tgt   = to_rails(clip48(t_wide'(vd) * t_wide'(g)));
        delta = tgt - last_out;
        if (delta < 0) delta = -delta;
        r = '0;
        if (delta < BAND) begin
            at_rest = 1'b1;
            return 1'b0;
        end
        res = tgt;
        if (at_rest) begin
            res = clip48(t_wide'(last_out) + t_wide'(vd > 0 ? NUDGE : -NUDGE));
            at_rest = 1'b0;
        end else begin
            if (last_diff != vd) begin
                delta = last_diff - vd;
                if (delta < 0) delta = -delta;
                res = blended(last_out, vd, clip48(t_wide'(delta)), g);
            end
            at_rest = 1'b1;
        end
        res       = to_rails(res);
        last_diff = vd;
        last_out  = res;
        r.volt    = res[47:0];
        r.conv    = at_rest;
        return 1'b1;
    endfunction

    function automatic void mismatch(input string what, input longint want_v,
                                     input longint got_v);
        errs++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
    endfunction

    always @(posedge i_clk) begin
        ocs_pkg::t_result want;
        ocs_pkg::t_result seen;
        if (!i_rst_n) begin
            gain_now  = ocs_pkg::GAIN_RST;
            rail_hi   = ocs_pkg::SUP_HI_RST;
            rail_lo   = ocs_pkg::SUP_LO_RST;
            last_out  = 0;
            last_diff = 0;
            at_rest   = 1'b1;
            out_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    ocs_pkg::CFG_GAIN:   gain_now = longint'(i_cfg_data[ocs_pkg::GW-1:0]);
                    ocs_pkg::CFG_SUP_HI: rail_hi = longint'($signed(i_cfg_data));
                    ocs_pkg::CFG_SUP_LO: rail_lo = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.volt = i_m_tdata;
                seen.conv = i_m_tuser;
                beats++;
                if (out_due.size() == 0) begin
                    mismatch("unexpected beat, out_volt", 0, longint'($signed(seen.volt)));
                end else begin
                    want = out_due.pop_front();
                    if (want.volt !== seen.volt) begin
                        mismatch("out_volt", longint'($signed(want.volt)),
                                 longint'($signed(seen.volt)));
                    end
                    if (want.conv !== seen.conv) begin
                        mismatch("now_converged", longint'(want.conv), longint'(seen.conv));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (next_output(longint'($signed(i_s_tdata[47:0])),
                                longint'($signed(i_s_tdata[95:48])), want)) begin
                    out_due.push_back(want);
                end else begin
                    quiet++;
                end
            end
        end
        o_errors  <= errs;
        o_pending <= out_due.size();
        o_beats   <= beats;
        o_quiet   <= quiet;
    end

endmodule

// File: bench/opamp_convergence_step_test.sv
`timescale 1ns / 1ps
module opamp_convergence_step_test;

    localparam int     LIMIT     = 1_000_000;
    localparam int     SETTLE    = 250;
    localparam int     PER_SET   = 190;
    localparam longint V_MAX     = (longint'(1) <<< 47) - 1;
    localparam longint V_MIN     = -(longint'(1) <<< 47);
    localparam longint VOLT      = longint'(1) <<< ocs_pkg::FRAC_BITS_DEF;
    localparam logic [ocs_pkg::IDXW-1:0] CFG_SPARE = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;

    int     errors;
    int     pending;
    int     beats;
    int     quiet;
    int     cycle_count = 0;
    int     steps_sent = 0;
    int     m_hold = 0;
    bit     calm = 1'b0;
    longint cur_gain = ocs_pkg::GAIN_RST;
    longint cur_hi = ocs_pkg::SUP_HI_RST;
    longint cur_lo = ocs_pkg::SUP_LO_RST;

    always #2 clk = ~clk;

    opamp_convergence_step dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    opamp_convergence_step_checker step_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_beats     (beats),
        .o_quiet     (quiet)
    );

    // receiver may stall for a random hold after a beat, except in calm runs
    always @(posedge clk) begin
        int hold;
        if (!rst_n) begin
            m_tready <= 1'b0;
            m_hold   <= 0;
        end else if (m_hold != 0) begin
            m_hold <= m_hold - 1;
            if (m_hold == 1) m_tready <= 1'b1;
        end else if (!m_tready) begin
            m_tready <= 1'b1;
        end else if (m_tvalid && !calm) begin
            hold = $urandom_range(0, 4);
            if (hold != 0) begin
                m_tready <= 1'b0;
                m_hold   <= hold;
            end
        end
    end

    function automatic longint rand_between(input longint lo, input longint hi);
        longint span;
        span = hi - lo + 1;
        return lo + longint'({$urandom, $urandom} >> 16) % span;
    endfunction

    // difference that mostly lands the target between the rails
    function automatic longint pick_base();
        longint g;
        longint a;
        longint b;
        g = (cur_gain == 0) ? 1 : cur_gain;
        a = cur_lo / g;
        b = cur_hi / g;
        if ($urandom_range(0, 7) == 0) return rand_between(V_MIN, V_MAX);
        if (a > b) return rand_between(b, a);
        return rand_between(a, b);
    endfunction

    task automatic send_step(input logic [47:0] vp, input logic [47:0] vm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vm, vp};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        steps_sent++;
    endtask

    task automatic wait_quiet(input int tail);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ocs_pkg::IDXW-1:0] idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_rails(input logic [ocs_pkg::GW-1:0] g, input longint hi,
                             input longint lo);
        write_reg(ocs_pkg::CFG_GAIN, {28'($urandom), g});
        write_reg(ocs_pkg::CFG_SUP_HI, 48'(hi));
        write_reg(ocs_pkg::CFG_SUP_LO, 48'(lo));
        cur_gain = g;
        cur_hi   = hi;
        cur_lo   = lo;
    endtask

    // runs of steps that repeat, nudge or re-pick one difference, plus raw noise
    task automatic random_steps(input int count);
        longint vd;
        longint vm;
        int     left;
        int     run;
        int     kind;
        left = count;
        while (left > 0) begin
            calm = ($urandom_range(0, 5) == 0);
            run  = $urandom_range(1, 5);
            vd   = pick_base();
            for (int i = 0; i < run && left > 0; i++) begin
                kind = $urandom_range(0, 19);
                if (kind < 3) begin
                    send_step(48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
                end else begin
                    if (kind < 7) begin
                        vd = pick_base();
                    end else if (kind < 12) begin
                        vm = longint'(1) <<< $urandom_range(0, 30);
                        vd = vd + rand_between(-vm, vm);
                        if (vd > V_MAX) vd = V_MAX;
                        if (vd < V_MIN) vd = V_MIN;
                    end
                    if (vd >= 0) vm = rand_between(V_MIN, V_MAX - vd);
                    else vm = rand_between(V_MIN - vd, V_MAX);
                    send_step(48'(vm + vd), 48'(vm));
                end
                left--;
                if (left % 61 == 0) wait_quiet(0);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        longint a;
        longint b;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: saturation, nudges both ways, direct and blended steps
        send_step(48'(V_MAX), 48'(V_MIN));
        send_step(48'(V_MAX), 48'(V_MIN));
        send_step(48'(V_MAX), 48'(V_MIN));
        send_step(48'(V_MIN), 48'(V_MAX));
        send_step(48'(longint'(1) <<< 20), 48'(0));
        send_step(48'(12345), 48'(12345));
        send_step(48'(0), 48'(0));
        send_step(48'(-1), 48'(-1));
        send_step(48'(0), 48'(0));
        send_step(48'(4294967), 48'(0));
        send_step(48'(4295967), 48'(0));
        send_step(48'(4295967), 48'(0));
        send_step(48'(V_MAX), 48'(V_MAX));
        send_step(48'(V_MIN), 48'(V_MIN));
        send_step(48'(-1), 48'(0));
        send_step(48'(0), 48'(-1));
        send_step(48'(V_MAX), 48'(0));
        send_step(48'(0), 48'(V_MIN));
        send_step(48'(V_MIN), 48'(1));
        wait_quiet(SETTLE);

        set_rails(20'd1, V_MAX, V_MIN);
        random_steps(PER_SET);
        wait_quiet(SETTLE);

        set_rails(20'hFFFFF, 5 * VOLT, -5 * VOLT);
        random_steps(PER_SET);
        wait_quiet(SETTLE);

        // zero gain with crossed rails
        set_rails(20'd0, -VOLT, VOLT);
        random_steps(PER_SET);
        wait_quiet(SETTLE);

        a = rand_between(V_MIN, V_MAX);
        b = rand_between(V_MIN, V_MAX);
        set_rails(20'($urandom_range(1, 1000000)), (a > b) ? a : b, (a > b) ? b : a);
        random_steps(PER_SET);
        wait_quiet(SETTLE);

        write_reg(CFG_SPARE, 48'({$urandom, $urandom}));
        set_rails(20'd1000000, 5 * VOLT, 0);
        random_steps(PER_SET);
        wait_quiet(SETTLE);

        if (pending != 0) $display("%0t: %0d expected beats never arrived", $time, pending);
        $display("sent %0d steps under six gain and rail settings: unit, zero and full-scale",
                 steps_sent);
        $display("gain, crossed rails; %0d output beats compared, %0d steps settled silently",
                 beats, quiet);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run exceeded %0d cycles", $time, LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/ocs_pkg.sv
hw/rtl/ocs_alu.sv
hw/rtl/ocs_core.sv
hw/rtl/opamp_convergence_step.sv
hw/rtl/ocs_checker.sv
bench/opamp_convergence_step_checker.sv
bench/opamp_convergence_step_test.sv
